// ===== src/fnv1_pkg.sv =====
// package: types, codes and hash fold for the fnv-1 hash table
`default_nettype none

package fnv1_pkg;

    localparam int HASH_W           = 64;
    localparam int VALUE_W          = 64;
    localparam int COUNT_W          = 11;
    localparam int BUCKET_BITS_DEF  = 8;
    localparam int WAYS_DEF         = 4;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

    typedef enum logic [1:0] {
        CMD_PUT = 2'd0,
        CMD_GET = 2'd1,
        CMD_POP = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_UPDATE
    } t_state;

    typedef struct packed {
        t_cmd               command;
        logic [7:0]         key_byte;
        logic               byte_present;
        logic               last;
        logic [VALUE_W-1:0] put_value;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] read_value;
        t_status            status;
        logic [COUNT_W-1:0] entry_count;
    } t_out_item;

    // multiply by prime 2^40 + 0x1b3 as shift-add, then xor the byte
    function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
        logic [HASH_W-1:0] p;
        p = h + (h << 1) + (h << 4) + (h << 5) + (h << 7) + (h << 8) + (h << 40);
        return p ^ {{(HASH_W-8){1'b0}}, b};
    endfunction

endpackage

`default_nettype wire

// ===== src/fnv1_hash_table.sv =====
// top level: fnv-1 keyed store with bucket memory read-modify-write
//
// channel   direction  handshake                 payload
// command   in         i_start, o_busy           i_item   (fnv1_pkg::t_in_item)
// result    out        o_valid (one-cycle strobe) o_result (fnv1_pkg::t_out_item)
//
// a key byte without last leaves busy low; the next transfer may follow at once
// a last byte holds busy through the bucket row read, then the modify and write back
// the result strobe comes in the cycle after the write back; the receiver cannot stall
// after reset a clearing pass writes every bucket row, with busy high
`default_nettype none

module fnv1_hash_table #(
    parameter int BUCKET_BITS = fnv1_pkg::BUCKET_BITS_DEF,
    parameter int WAYS        = fnv1_pkg::WAYS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    output logic                o_busy,
    input  fnv1_pkg::t_in_item  i_item,
    output logic                o_valid,
    output fnv1_pkg::t_out_item o_result
);

    localparam int HASH_W     = fnv1_pkg::HASH_W;
    localparam int VALUE_W    = fnv1_pkg::VALUE_W;
    localparam int COUNT_W    = fnv1_pkg::COUNT_W;
    localparam int BUCKET_CNT = 1 << BUCKET_BITS;

    // tag row: per way {valid, hash}
    logic [WAYS-1:0][HASH_W:0]    mem_tag [BUCKET_CNT];
    logic [WAYS-1:0][VALUE_W-1:0] mem_val [BUCKET_CNT];

    fnv1_pkg::t_state    r_state, n_state;
    logic [BUCKET_BITS-1:0] r_clr_addr, n_clr_addr;
    logic [HASH_W-1:0]   r_hash, n_hash;
    logic [HASH_W-1:0]   r_key, n_key;
    fnv1_pkg::t_cmd      r_cmd, n_cmd;
    logic [VALUE_W-1:0]  r_put_value, n_put_value;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_valid, n_valid;
    fnv1_pkg::t_out_item r_result, n_result;

    logic [WAYS-1:0][HASH_W:0]    r_rd_tag;
    logic [WAYS-1:0][VALUE_W-1:0] r_rd_val;

    logic                         rd_en;
    logic                         wr_en;
    logic [BUCKET_BITS-1:0]       wr_addr;
    logic [WAYS-1:0][HASH_W:0]    wr_tag;
    logic [WAYS-1:0][VALUE_W-1:0] wr_val;

    logic [HASH_W-1:0]            folded;
    logic [WAYS-1:0]              hit_oh, free_oh;
    logic                         hit_seen, free_seen;
    logic [VALUE_W-1:0]           hit_value;
    logic [WAYS-1:0][HASH_W:0]    upd_tag;
    logic [WAYS-1:0][VALUE_W-1:0] upd_val;
    logic [VALUE_W-1:0]           rv;
    fnv1_pkg::t_status            status;

    assign folded = i_item.byte_present ? fnv1_pkg::fnv_fold(r_hash, i_item.key_byte)
                                        : r_hash;

    // bucket lookup on the row read back
    always_comb begin
        hit_oh    = '0;
        free_oh   = '0;
        hit_seen  = 1'b0;
        free_seen = 1'b0;
        hit_value = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (r_rd_tag[w][HASH_W] && (r_rd_tag[w][HASH_W-1:0] == r_key) && !hit_seen) begin
                hit_oh[w] = 1'b1;
                hit_seen  = 1'b1;
            end
            if (!r_rd_tag[w][HASH_W] && !free_seen) begin
                free_oh[w] = 1'b1;
                free_seen  = 1'b1;
            end
            if (hit_oh[w]) begin
                hit_value = r_rd_val[w];
            end
        end
    end

    // modify
    always_comb begin
        upd_tag = r_rd_tag;
        upd_val = r_rd_val;
        rv      = '0;
        status  = fnv1_pkg::ST_OK;
        n_count = r_count;
        unique case (r_cmd)
            fnv1_pkg::CMD_PUT: begin
                if (hit_seen) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (hit_oh[w]) begin
                            upd_val[w] = r_put_value;
                        end
                    end
                end else if (free_seen) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (free_oh[w]) begin
                            upd_tag[w] = {1'b1, r_key};
                            upd_val[w] = r_put_value;
                        end
                    end
                    n_count = r_count + COUNT_W'(1);
                end else begin
                    status = fnv1_pkg::ST_FULL;
                end
            end
            fnv1_pkg::CMD_GET: begin
                if (hit_seen) begin
                    rv = hit_value;
                end else begin
                    status = fnv1_pkg::ST_MISS;
                end
            end
            fnv1_pkg::CMD_POP: begin
                if (hit_seen) begin
                    rv = hit_value;
                    for (int w = 0; w < WAYS; w++) begin
                        if (hit_oh[w]) begin
                            upd_tag[w][HASH_W] = 1'b0;
                        end
                    end
                    n_count = r_count - COUNT_W'(1);
                end else begin
                    status = fnv1_pkg::ST_MISS;
                end
            end
            default: begin
            end
        endcase
    end

    // control
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_hash      = r_hash;
        n_key       = r_key;
        n_cmd       = r_cmd;
        n_put_value = r_put_value;
        n_valid     = 1'b0;
        n_result    = r_result;
        o_busy      = 1'b1;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_clr_addr;
        wr_tag      = '0;
        wr_val      = '0;
        unique case (r_state)
            fnv1_pkg::S_CLEAR: begin
                wr_en      = 1'b1;
                n_clr_addr = r_clr_addr + BUCKET_BITS'(1);
                if (r_clr_addr == {BUCKET_BITS{1'b1}}) begin
                    n_state = fnv1_pkg::S_IDLE;
                end
            end
            fnv1_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    if (i_item.last) begin
                        n_key       = folded;
                        n_hash      = fnv1_pkg::FNV_BASIS;
                        n_cmd       = i_item.command;
                        n_put_value = i_item.put_value;
                        n_state     = fnv1_pkg::S_READ;
                    end else begin
                        n_hash = folded;
                    end
                end
            end
            fnv1_pkg::S_READ: begin
                rd_en   = 1'b1;
                n_state = fnv1_pkg::S_UPDATE;
            end
            fnv1_pkg::S_UPDATE: begin
                wr_en                = 1'b1;
                wr_addr              = r_key[BUCKET_BITS-1:0];
                wr_tag               = upd_tag;
                wr_val               = upd_val;
                n_valid              = 1'b1;
                n_result.found       = hit_seen;
                n_result.read_value  = rv;
                n_result.status      = status;
                n_result.entry_count = n_count;
                n_state              = fnv1_pkg::S_IDLE;
            end
            default: begin
                n_state = fnv1_pkg::S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fnv1_pkg::S_CLEAR;
            r_clr_addr <= '0;
            r_hash     <= fnv1_pkg::FNV_BASIS;
            r_count    <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_hash     <= n_hash;
            r_valid    <= n_valid;
            if (r_state == fnv1_pkg::S_UPDATE) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_cmd       <= n_cmd;
        r_put_value <= n_put_value;
        r_result    <= n_result;
    end

    // bucket memories
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_tag[wr_addr] <= wr_tag;
            mem_val[wr_addr] <= wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_tag <= mem_tag[r_key[BUCKET_BITS-1:0]];
            r_rd_val <= mem_val[r_key[BUCKET_BITS-1:0]];
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== bench/fnv1_hash_table_tb.sv =====
`timescale 1ns / 1ps
// testbench: fnv-1 keyed store checked transfer by transfer against a behavioural table model
module fnv1_hash_table_tb;
    import fnv1_pkg::*;

    localparam int BKT_BITS     = 8;
    localparam int NWAYS        = 4;
    localparam int NSLOTS       = (1 << BKT_BITS) * NWAYS;
    localparam logic [63:0] FNV_PRIME_C = 64'h0000_0100_0000_01b3;
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int ITEM_TARGET  = 1950;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DIR_N        = 25;
    localparam int K_EMPTY      = 6;
    localparam int K_FF         = 7;
    localparam int K_ZERO       = 8;

    localparam logic [63:0] ONES = {64{1'b1}};
    localparam logic [63:0] V1   = 64'h0123_4567_89ab_cdef;
    localparam logic [63:0] V2   = 64'hfedc_ba98_7654_3210;
    localparam logic [63:0] V3   = 64'h5555_aaaa_0f0f_f0f0;
    localparam logic [63:0] V4   = 64'h1357_9bdf_2468_ace0;
    localparam logic [63:0] VE   = 64'h8000_0000_0000_0001;

    typedef struct packed {
        logic [3:0]      len;
        logic [7:0][7:0] bytes;
    } t_key;

    typedef struct packed {
        int          key;
        logic [1:0]  cmd;
        logic [63:0] value;
        logic        typed;
        logic        found;
        logic [63:0] rv;
        t_status     status;
        logic [10:0] count;
    } t_row;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_start = 1'b0;
    t_in_item   i_item  = '0;
    logic       o_busy;
    logic       o_valid;
    t_out_item  o_result;

    logic [63:0] fold_hash;
    logic        slot_used [NSLOTS];
    logic [63:0] slot_key  [NSLOTS];
    logic [63:0] slot_data [NSLOTS];
    logic [10:0] used_count;

    t_out_item   pending_results [$];
    t_out_item   due_result;
    t_key        key_pool [$];
    int          mismatches  = 0;
    int          items_sent  = 0;
    bit          calm        = 1'b0;

    fnv1_hash_table #(
        .BUCKET_BITS(BKT_BITS),
        .WAYS       (NWAYS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [63:0] fold_byte(input logic [63:0] h, input logic [7:0] b);
        return (h * FNV_PRIME_C) ^ {56'd0, b};
    endfunction

    function automatic logic [63:0] key_digest(input t_key k);
        logic [63:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < int'(k.len); i++)
            h = fold_byte(h, k.bytes[i]);
        return h;
    endfunction

    function automatic void table_reset();
        fold_hash  = FNV_BASIS;
        used_count = '0;
        for (int s = 0; s < NSLOTS; s++)
            slot_used[s] = 1'b0;
    endfunction

    function automatic bit table_step(input t_in_item it, output t_out_item r);
        logic [63:0] h;
        int          base;
        int          hit;
        r = '0;
        if (it.byte_present)
            fold_hash = fold_byte(fold_hash, it.key_byte);
        if (!it.last)
            return 1'b0;
        h         = fold_hash;
        fold_hash = FNV_BASIS;
        base      = int'(h[BKT_BITS-1:0]) * NWAYS;
        hit       = -1;
        for (int w = 0; w < NWAYS; w++)
            if (hit < 0 && slot_used[base+w] && slot_key[base+w] == h)
                hit = base + w;
        r.found  = (hit >= 0);
        r.status = ST_OK;
        case (it.command)
            CMD_PUT: begin
                if (hit >= 0) begin
                    slot_data[hit] = it.put_value;
                end else begin
                    r.status = ST_FULL;
                    for (int w = 0; w < NWAYS; w++) begin
                        if (r.status == ST_FULL && !slot_used[base+w]) begin
                            slot_used[base+w] = 1'b1;
                            slot_key[base+w]  = h;
                            slot_data[base+w] = it.put_value;
                            used_count        = used_count + 11'd1;
                            r.status          = ST_OK;
                        end
                    end
                end
            end
            CMD_GET, CMD_POP: begin
                if (hit >= 0) begin
                    r.read_value = slot_data[hit];
                    if (it.command == CMD_POP) begin
                        slot_used[hit] = 1'b0;
                        if (used_count != 0)
                            used_count = used_count - 11'd1;
                    end
                end else begin
                    r.status = ST_MISS;
                end
            end
            default: ;
        endcase
        r.entry_count = used_count;
        return 1'b1;
    endfunction

    task automatic add_bucket_keys(input logic [7:0] bkt, input int n);
        t_key        k;
        logic [63:0] h;
        int          got;
        bit          dup;
        got = 0;
        while (got < n) begin
            k.len   = 4'd3;
            k.bytes = {$urandom, $urandom};
            h       = key_digest(k);
            if (h[BKT_BITS-1:0] == bkt) begin
                dup = 1'b0;
                foreach (key_pool[j])
                    if (key_digest(key_pool[j]) == h)
                        dup = 1'b1;
                if (!dup) begin
                    key_pool.push_back(k);
                    got++;
                end
            end
        end
    endtask

    task automatic send_item(input t_in_item it, input logic use_row, input t_row row);
        t_out_item r;
        while (!calm && $urandom_range(99) < 20) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        if (table_step(it, r)) begin
            if (use_row && row.typed) begin
                r.found       = row.found;
                r.read_value  = row.rv;
                r.status      = row.status;
                r.entry_count = row.count;
            end
            pending_results.push_back(r);
        end
        items_sent++;
    endtask

    task automatic send_key(input t_key k, input logic [1:0] cmd, input logic [63:0] value,
                            input logic use_row, input t_row row);
        t_in_item it;
        int       steps;
        steps = (k.len == 0) ? 1 : int'(k.len);
        for (int i = 0; i < steps; i++) begin
            if ($urandom_range(99) < 8) begin
                it.command      = t_cmd'($urandom_range(3));
                it.key_byte     = 8'($urandom);
                it.byte_present = 1'b0;
                it.last         = 1'b0;
                it.put_value    = {$urandom, $urandom};
                send_item(it, 1'b0, '0);
            end
            it.command      = t_cmd'($urandom_range(3));
            it.key_byte     = (k.len == 0) ? 8'($urandom) : k.bytes[i];
            it.byte_present = (k.len != 0);
            it.last         = (i == steps - 1);
            it.put_value    = {$urandom, $urandom};
            if (it.last) begin
                it.command   = t_cmd'(cmd);
                it.put_value = value;
            end
            send_item(it, use_row, row);
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no expectation waiting");
                mismatches++;
            end else begin
                due_result = pending_results.pop_front();
                if (o_result.found !== due_result.found) begin
                    $error("found: expected %0d, got %0d", due_result.found, o_result.found);
                    mismatches++;
                end
                if (o_result.read_value !== due_result.read_value) begin
                    $error("read_value: expected %h, got %h",
                           due_result.read_value, o_result.read_value);
                    mismatches++;
                end
                if (o_result.status !== due_result.status) begin
                    $error("status: expected %0d, got %0d", due_result.status, o_result.status);
                    mismatches++;
                end
                if (o_result.entry_count !== due_result.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           due_result.entry_count, o_result.entry_count);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #(LIMIT_CYCLES * 12);
        $display("fnv1_hash_table: mismatch");
        $finish;
    end

    initial begin
        t_key        k;
        t_row        dir_rows [DIR_N];
        t_in_item    blank;
        logic [1:0]  cmd;
        logic [63:0] v;
        int          roll;

        table_reset();
        add_bucket_keys(8'h5a, 6);
        k.len = 4'd0; k.bytes = '0;            key_pool.push_back(k);
        k.len = 4'd8; k.bytes = '1;            key_pool.push_back(k);
        k.len = 4'd1; k.bytes = '0;            key_pool.push_back(k);
        k.len = 4'd8; k.bytes = '0;            key_pool.push_back(k);
        for (int b = 0; b < 3; b++)
            add_bucket_keys(8'($urandom_range(255)), 6);
        for (int n = 0; n < 20; n++) begin
            k.len   = 4'($urandom_range(1, 6));
            k.bytes = {$urandom, $urandom};
            key_pool.push_back(k);
        end

        dir_rows = '{
            '{K_EMPTY, CMD_GET,  64'd0, 1'b1, 1'b0, 64'd0, ST_MISS, 11'd0},
            '{0,       CMD_POP,  64'd0, 1'b1, 1'b0, 64'd0, ST_MISS, 11'd0},
            '{0,       CMD_PUT,  ONES,  1'b1, 1'b0, 64'd0, ST_OK,   11'd1},
            '{0,       CMD_GET,  64'd0, 1'b1, 1'b1, ONES,  ST_OK,   11'd1},
            '{0,       CMD_PUT,  64'd0, 1'b1, 1'b1, 64'd0, ST_OK,   11'd1},
            '{0,       CMD_GET,  V1,    1'b1, 1'b1, 64'd0, ST_OK,   11'd1},
            '{1,       CMD_PUT,  V1,    1'b1, 1'b0, 64'd0, ST_OK,   11'd2},
            '{2,       CMD_PUT,  V2,    1'b1, 1'b0, 64'd0, ST_OK,   11'd3},
            '{3,       CMD_PUT,  V3,    1'b1, 1'b0, 64'd0, ST_OK,   11'd4},
            '{4,       CMD_PUT,  V4,    1'b1, 1'b0, 64'd0, ST_FULL, 11'd4},
            '{4,       CMD_GET,  64'd0, 1'b1, 1'b0, 64'd0, ST_MISS, 11'd4},
            '{1,       CMD_NONE, V4,    1'b1, 1'b1, 64'd0, ST_OK,   11'd4},
            '{4,       CMD_NONE, V4,    1'b1, 1'b0, 64'd0, ST_OK,   11'd4},
            '{2,       CMD_POP,  64'd0, 1'b1, 1'b1, V2,    ST_OK,   11'd3},
            '{2,       CMD_GET,  64'd0, 1'b1, 1'b0, 64'd0, ST_MISS, 11'd3},
            '{4,       CMD_PUT,  V4,    1'b1, 1'b0, 64'd0, ST_OK,   11'd4},
            '{4,       CMD_GET,  64'd0, 1'b1, 1'b1, V4,    ST_OK,   11'd4},
            '{3,       CMD_POP,  64'd0, 1'b1, 1'b1, V3,    ST_OK,   11'd3},
            '{K_EMPTY, CMD_PUT,  VE,    1'b1, 1'b0, 64'd0, ST_OK,   11'd4},
            '{K_EMPTY, CMD_GET,  64'd0, 1'b1, 1'b1, VE,    ST_OK,   11'd4},
            '{K_FF,    CMD_PUT,  V2,    1'b0, 1'b0, 64'd0, ST_OK,   11'd0},
            '{K_ZERO,  CMD_PUT,  ONES,  1'b0, 1'b0, 64'd0, ST_OK,   11'd0},
            '{K_FF,    CMD_POP,  64'd0, 1'b0, 1'b0, 64'd0, ST_OK,   11'd0},
            '{K_ZERO,  CMD_GET,  64'd0, 1'b0, 1'b0, 64'd0, ST_OK,   11'd0},
            '{K_EMPTY, CMD_POP,  64'd0, 1'b0, 1'b0, 64'd0, ST_OK,   11'd0}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // step with neither a byte nor last
        blank           = '0;
        blank.put_value = ONES;
        send_item(blank, 1'b0, '0);

        for (int r = 0; r < DIR_N; r++)
            send_key(key_pool[dir_rows[r].key], dir_rows[r].cmd, dir_rows[r].value,
                     1'b1, dir_rows[r]);
        drain();

        while (items_sent < ITEM_TARGET) begin
            calm = (items_sent >= 900 && items_sent < 1300);
            if ($urandom_range(99) < 15) begin
                k.len   = 4'($urandom_range(8));
                k.bytes = {$urandom, $urandom};
            end else begin
                k = key_pool[$urandom_range(key_pool.size() - 1)];
            end
            roll = $urandom_range(99);
            if (roll < 40)
                cmd = CMD_PUT;
            else if (roll < 70)
                cmd = CMD_GET;
            else if (roll < 95)
                cmd = CMD_POP;
            else
                cmd = CMD_NONE;
            roll = $urandom_range(99);
            if (roll < 5)
                v = ONES;
            else if (roll < 10)
                v = 64'd0;
            else
                v = {$urandom, $urandom};
            send_key(k, cmd, v, 1'b0, '0);
            if ($urandom_range(249) == 0)
                drain();
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("fnv1_hash_table: match");
        else
            $display("fnv1_hash_table: mismatch");
        $finish;
    end

endmodule
